/* src/its_pkg.sv */
// ----------------------------------------------------------------------------
// its_pkg
// Shared constants and types of the identifier token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package its_pkg;

	localparam int DefMaxBuffer = 1048576;

	localparam int ChW       = 8;
	localparam int OffW      = 20;
	localparam int LenW      = 21;
	localparam int InDataW   = 8;
	localparam int OutDataW  = 48;
	localparam int QueueDepth = 4;

	localparam logic [ChW-1:0] CharNul        = 8'h00;
	localparam logic [ChW-1:0] CharUnderscore = 8'h5F;
	localparam logic [ChW-1:0] CharColon      = 8'h3A;
	localparam logic [ChW-1:0] CharLowA       = 8'h61;
	localparam logic [ChW-1:0] CharLowZ       = 8'h7A;
	localparam logic [ChW-1:0] CharUpA        = 8'h41;
	localparam logic [ChW-1:0] CharUpZ        = 8'h5A;
	localparam logic [ChW-1:0] CharDig0       = 8'h30;
	localparam logic [ChW-1:0] CharDig9       = 8'h39;

	// one closed token, with its optional suffix
	typedef struct packed {
		logic [OffW-1:0] off;
		logic [LenW-1:0] len;
		logic            has_sfx;
		logic [OffW-1:0] sfx_off;
		logic [LenW-1:0] sfx_len;
	} its_rec_t;

	typedef struct packed {
		logic     valid;
		its_rec_t rec;
	} its_push_t;

	typedef struct packed {
		logic     valid;
		its_rec_t rec;
	} its_head_t;

endpackage

`default_nettype wire

/* src/its_front.sv */
// ----------------------------------------------------------------------------
// its_front
// Takes one byte per item, classifies it and tracks the open token; pushes a
// record into the queue whenever a token closes.
// ----------------------------------------------------------------------------
`default_nettype none

module its_front #(
	parameter int MAX_BUFFER = its_pkg::DefMaxBuffer
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic                   cfg_wr_data,
	input  wire logic [its_pkg::ChW-1:0] ch,
	input  wire logic                   last_byte,
	input  wire logic                   accept,
	output its_pkg::its_push_t          push
);
	import its_pkg::*;

	localparam int PosW = $clog2(MAX_BUFFER + 1);

	logic            mode_q;
	logic [PosW-1:0] pos_q;
	logic            in_tok_q;
	logic [PosW-1:0] begin_q;
	logic            colon_q;
	logic [PosW-1:0] colon_at_q;
	logic            stop_q;

	logic            active;
	logic            over;
	logic            starts;
	logic            conts;
	logic            brk;
	logic            in_tok_d;
	logic [PosW-1:0] begin_d;
	logic            colon_d;
	logic [PosW-1:0] colon_at_d;
	logic            stop_d;
	logic [PosW-1:0] pos_inc;
	logic            close_en;
	logic [PosW-1:0] close_end;
	logic [PosW-1:0] sfx_start;
	logic [PosW-1:0] tok_len;
	logic [PosW-1:0] sfx_len;

	always_comb begin
		active  = accept & ~stop_q;
		over    = pos_q >= PosW'(MAX_BUFFER);
		pos_inc = pos_q + PosW'(1);
		starts  = (ch == CharUnderscore) || (ch inside {[CharLowA:CharLowZ]})
			|| (ch inside {[CharUpA:CharUpZ]});
		conts   = starts || (ch inside {[CharDig0:CharDig9]})
			|| (mode_q && ch == CharColon);

		in_tok_d   = in_tok_q;
		begin_d    = begin_q;
		colon_d    = colon_q;
		colon_at_d = colon_at_q;
		stop_d     = stop_q;
		brk        = 1'b0;
		if (active && !over) begin
			if (!in_tok_q) begin
				if (starts) begin
					in_tok_d = 1'b1;
					begin_d  = pos_q;
					colon_d  = 1'b0;
				end
			end else if (conts) begin
				if (ch == CharColon && !colon_q) begin
					colon_d    = 1'b1;
					colon_at_d = pos_q;
				end
			end else begin
				brk = 1'b1;
			end
			if (ch == CharNul || last_byte) begin
				stop_d = 1'b1;
			end
		end else if (active && last_byte) begin
			stop_d = 1'b1;
		end

		close_en  = active && (brk || (last_byte && in_tok_d));
		close_end = (brk || over) ? pos_q : pos_inc;
		sfx_start = colon_at_d + PosW'(1);
		tok_len   = close_end - begin_d;
		sfx_len   = (close_end >= sfx_start) ? close_end - sfx_start : '0;

		push.valid       = close_en;
		push.rec.off     = OffW'(begin_d);
		push.rec.len     = LenW'(tok_len);
		push.rec.has_sfx = colon_d;
		push.rec.sfx_off = OffW'(sfx_start);
		push.rec.sfx_len = LenW'(sfx_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			pos_q      <= '0;
			in_tok_q   <= 1'b0;
			begin_q    <= '0;
			colon_q    <= 1'b0;
			colon_at_q <= '0;
			stop_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (active) begin
				if (!over) begin
					pos_q <= pos_inc;
				end
				in_tok_q   <= close_en ? 1'b0 : in_tok_d;
				colon_q    <= close_en ? 1'b0 : colon_d;
				begin_q    <= begin_d;
				colon_at_q <= colon_at_d;
				stop_q     <= stop_d;
			end
		end
	end

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |=> stop_q)
		else $error("scan restarted after stop");

	a_colon_in_tok: assert property (@(posedge clk) disable iff (!arst_n)
		colon_q |-> in_tok_q)
		else $error("colon flag set outside a token");

	a_begin_order: assert property (@(posedge clk) disable iff (!arst_n)
		in_tok_q |-> (begin_q < pos_q))
		else $error("token start not behind position");

	a_no_close_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |-> !push.valid)
		else $error("token closed after stop");

endmodule

`default_nettype wire

/* src/its_queue.sv */
// ----------------------------------------------------------------------------
// its_queue
// Short queue of closed token records between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module its_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  its_pkg::its_push_t push,
	input  wire logic          pop,
	output logic               full,
	output its_pkg::its_head_t head
);
	import its_pkg::*;

	localparam int IdxW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	its_rec_t        mem_q [QueueDepth];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full      = count_q == CntW'(QueueDepth);
	assign do_push   = push.valid & ~full;
	assign do_pop    = pop & head.valid;
	assign head.valid = count_q != '0;
	assign head.rec  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IdxW'(QueueDepth - 1)) ? '0 : wr_ptr_q + IdxW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IdxW'(QueueDepth - 1)) ? '0 : rd_ptr_q + IdxW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QueueDepth))
		else $error("queue count overflow");

	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("record pushed into a full queue");

	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from an empty queue");

endmodule

`default_nettype wire

/* src/its_back.sv */
// ----------------------------------------------------------------------------
// its_back
// Turns each queued record into one or two result items on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module its_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  its_pkg::its_head_t                 head,
	output logic                               pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [its_pkg::OutDataW-1:0]       m_tdata,
	output logic                               m_tuser,
	output logic                               m_tlast
);
	import its_pkg::*;

	logic            sfx_phase_q;
	logic            fire;
	logic [OffW-1:0] off;
	logic [LenW-1:0] len;

	assign m_tvalid = head.valid;
	assign fire     = m_tvalid & m_tready;
	assign off      = sfx_phase_q ? head.rec.sfx_off : head.rec.off;
	assign len      = sfx_phase_q ? head.rec.sfx_len : head.rec.len;
	assign m_tdata  = {(OutDataW - OffW - LenW)'(0), len, off};
	assign m_tuser  = sfx_phase_q;
	assign m_tlast  = sfx_phase_q | ~head.rec.has_sfx;
	assign pop      = fire & m_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sfx_phase_q <= 1'b0;
		end else if (fire) begin
			sfx_phase_q <= ~m_tlast;
		end
	end

	a_phase_has_sfx: assert property (@(posedge clk) disable iff (!arst_n)
		sfx_phase_q |-> (head.valid && head.rec.has_sfx))
		else $error("suffix phase without a suffix record");

	a_phase_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(sfx_phase_q && !fire) |=> sfx_phase_q)
		else $error("suffix phase dropped before delivery");

	a_token_then_sfx: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !m_tlast) |=> (sfx_phase_q && m_tvalid))
		else $error("suffix item missing after its token");

endmodule

`default_nettype wire

/* src/identifier_token_scanner.sv */
// ----------------------------------------------------------------------------
// identifier_token_scanner
// Scans a byte stream and reports offset and length of every identifier.
// ----------------------------------------------------------------------------
// One byte is taken each cycle unless the queue is full. Every closed
// identifier is written as a record into a four-entry queue; the output side
// drains one result item per cycle while m_tready is high, so an identifier
// with a colon in script mode yields two items (token, then suffix). Input
// stalls only when that queue is full; a token's record is pushed as it closes.
`default_nettype none

module identifier_token_scanner #(
	parameter int MAX_BUFFER = its_pkg::DefMaxBuffer
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic                         cfg_wr_data,  // script_mode
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [its_pkg::InDataW-1:0]  s_tdata,      // ch
	input  wire logic                         s_tlast,      // last_byte
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [its_pkg::OutDataW-1:0]      m_tdata,      // token_offset, token_length
	output logic                              m_tuser,      // is_suffix
	output logic                              m_tlast       // last_of_run
);
	import its_pkg::*;

	its_push_t push;
	its_head_t head;
	logic      full;
	logic      pop;

	assign s_tready = ~full;

	its_front #(
		.MAX_BUFFER(MAX_BUFFER)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.ch         (s_tdata[ChW-1:0]),
		.last_byte  (s_tlast),
		.accept     (s_tvalid & s_tready),
		.push       (push)
	);

	its_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.full  (full),
		.head  (head)
	);

	its_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

`default_nettype wire
